FILE: rtl/tkac_pkg.sv
// Package for the top-K access count table.
// Holds depth constants, beat types, command codes and controller states.
package tkac_pkg;

   localparam int TableDepth = 16;
   localparam int IdxW       = $clog2(TableDepth);
   localparam int TotW       = $clog2(TableDepth + 1);
   localparam int OccW       = 5;

   localparam logic [1:0] KIND_OFFER   = 2'd0;
   localparam logic [1:0] KIND_UPDATE  = 2'd1;
   localparam logic [1:0] KIND_DEQUEUE = 2'd2;

   localparam logic [1:0] STAT_DONE     = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_REJECTED = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] block_number;
      logic [30:0] access_count;
   } req_type;

   typedef struct packed {
      logic [31:0]     head_block;
      logic [1:0]      status;
      logic            hit;
      logic [OccW-1:0] occupancy;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_BUB_READ,
      ST_BUB_WAIT,
      ST_BUB_CMP,
      ST_DEQ_WAIT,
      ST_RESPOND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic load_tail;      // pos := total-1 (replace) or total (insert)
      logic insert;         // total++ as pos is loaded, before the new entry is written
      logic write_new;      // write the request beat at pos
      logic pos_clear;      // pos := 0 for search
      logic pos_inc;
      logic read_pos;       // read entries at pos
      logic read_pair;      // read entries at pos and pos-1
      logic write_hit;      // store new count at pos
      logic swap;           // swap pos and pos-1, pos--
      logic read_head;
      logic dequeue;
      logic set_hit;
      logic set_status_empty;
      logic set_status_rej;
      logic respond;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] kind;
      logic full;
      logic empty;
      logic tail_cmp_gt;   // new count larger than tail count
      logic search_end;    // pos reached total
      logic match;         // entry at pos holds the block
      logic pos_zero;
      logic pair_gt;       // count at pos larger than count at pos-1
   } sts_type;

endpackage

FILE: rtl/top_k_access_count_table_top.sv
// Top level of the top-K access count table.
// Depends on tkac_pkg, tkac_ctrl and tkac_datapath.
//
// Keeps up to 16 (block, count) entries sorted by count, head first, in two
// small RAMs arranged as a ring. Raise start with a request beat while busy is
// low; busy then stays high until the one response beat, shown for a single
// cycle with rsp_strobe high. The receiver cannot stall, so capture it then.
// The time per item is set by the sequencer walking the RAM, and it differs
// for dequeue and for an offer into an empty table, with room, rejected or
// replacing the tail. An update first searches the entries one by one, and
// each swap toward the head adds to the time; the longest case is an update
// that misses on a full table and rises to the head.
// No clearing pass is needed after reset.
module top_k_access_count_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tkac_pkg::req_type req_beat,
   output logic              rsp_strobe,
   output tkac_pkg::rsp_type rsp_beat
);

   tkac_pkg::cmd_type cmd;
   tkac_pkg::sts_type sts;

   // sequence the search and bubble passes
   tkac_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .strobe(rsp_strobe), .sts, .cmd
   );

   // hold entries, ring pointers and the response beat
   tkac_datapath u_dp (
      .clock, .reset, .req_beat, .cmd, .sts, .rsp_beat
   );

endmodule

FILE: rtl/tkac_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No package dependency.
module tkac_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_a,
   output logic [Width-1:0]         rd_data_b
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

FILE: rtl/tkac_datapath.sv
// Datapath of the top-K table: entry memories, ring pointers, result register.
// Depends on tkac_pkg and tkac_ram.
module tkac_datapath (
   input  logic             clock,
   input  logic             reset,
   input  tkac_pkg::req_type req_beat,
   input  tkac_pkg::cmd_type cmd,
   output tkac_pkg::sts_type sts,
   output tkac_pkg::rsp_type rsp_beat
);

   localparam int IdxW = tkac_pkg::IdxW;
   localparam int TotW = tkac_pkg::TotW;

   tkac_pkg::req_type    req_ff;
   logic [IdxW-1:0]      head_ff, head_in;
   logic [TotW-1:0]      total_ff, total_in;
   logic [TotW-1:0]      pos_ff, pos_in;
   tkac_pkg::rsp_type    rsp_ff, rsp_in;

   // datapath-side swap buffer: second read port doubles as pos-1
   logic [IdxW-1:0] slot_pos, slot_prev, rd_a, rd_b, wr_addr;
   logic [31:0]     blk_a, blk_b, blk_wr;
   logic [30:0]     cnt_a, cnt_b, cnt_wr;
   logic            wr_en;
   // second write for a swap happens the cycle after
   logic            swap2_ff;
   logic [IdxW-1:0] swap2_addr_ff;
   logic [31:0]     swap2_blk_ff;
   logic [30:0]     swap2_cnt_ff;

   function automatic logic [IdxW-1:0] ring(input logic [IdxW-1:0] h,
                                            input logic [TotW-1:0] p);
      logic [TotW:0] s;
      s = {1'b0, {(TotW-IdxW){1'b0}}, h} + {1'b0, p};
      if (s >= (TotW+1)'(tkac_pkg::TableDepth)) begin
         s = s - (TotW+1)'(tkac_pkg::TableDepth);
      end
      return s[IdxW-1:0];
   endfunction

   assign slot_pos  = ring(head_ff, pos_ff);
   assign slot_prev = ring(head_ff, pos_ff - TotW'(1));
   assign rd_a = cmd.read_head ? head_ff : slot_pos;
   assign rd_b = slot_prev;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_pos;
      blk_wr  = req_ff.block_number;
      cnt_wr  = req_ff.access_count;
      if (swap2_ff) begin
         wr_en   = 1'b1;
         wr_addr = swap2_addr_ff;
         blk_wr  = swap2_blk_ff;
         cnt_wr  = swap2_cnt_ff;
      end else if (cmd.write_new) begin
         wr_en = 1'b1;
      end else if (cmd.write_hit) begin
         wr_en  = 1'b1;
         blk_wr = blk_a;
      end else if (cmd.swap) begin
         wr_en   = 1'b1;
         wr_addr = slot_prev;
         blk_wr  = blk_a;
         cnt_wr  = cnt_a;
      end
   end

   tkac_ram #(.Width(32), .Depth(tkac_pkg::TableDepth)) u_blk_ram (
      .clock, .wr_en, .wr_addr, .wr_data(blk_wr),
      .rd_addr_a(rd_a), .rd_addr_b(rd_b), .rd_data_a(blk_a), .rd_data_b(blk_b)
   );
   tkac_ram #(.Width(31), .Depth(tkac_pkg::TableDepth)) u_cnt_ram (
      .clock, .wr_en, .wr_addr, .wr_data(cnt_wr),
      .rd_addr_a(rd_a), .rd_addr_b(rd_b), .rd_data_a(cnt_a), .rd_data_b(cnt_b)
   );

   always_comb begin
      head_in  = head_ff;
      total_in = total_ff;
      pos_in   = pos_ff;
      rsp_in   = rsp_ff;
      if (cmd.latch_req) begin
         rsp_in = '0;
      end
      if (cmd.load_tail) begin
         pos_in = cmd.insert ? total_ff : total_ff - TotW'(1);
      end
      if (cmd.insert) begin
         total_in = total_ff + TotW'(1);
      end
      if (cmd.pos_clear) begin
         pos_in = '0;
      end
      if (cmd.pos_inc) begin
         pos_in = pos_ff + TotW'(1);
      end
      if (cmd.swap) begin
         pos_in = pos_ff - TotW'(1);
      end
      if (cmd.dequeue) begin
         rsp_in.head_block = blk_a;
         head_in  = ring(head_ff, TotW'(1));
         total_in = total_ff - TotW'(1);
      end
      if (cmd.set_hit) begin
         rsp_in.hit = 1'b1;
      end
      if (cmd.set_status_empty) begin
         rsp_in.status = tkac_pkg::STAT_EMPTY;
      end
      if (cmd.set_status_rej) begin
         rsp_in.status = tkac_pkg::STAT_REJECTED;
      end
      rsp_in.occupancy = tkac_pkg::OccW'(total_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         total_ff <= '0;
         swap2_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         total_ff <= total_in;
         swap2_ff <= cmd.swap;
      end
      pos_ff        <= pos_in;
      rsp_ff        <= rsp_in;
      swap2_addr_ff <= slot_pos;
      swap2_blk_ff  <= blk_b;
      swap2_cnt_ff  <= cnt_b;
      if (cmd.latch_req) begin
         req_ff <= req_beat;
      end
   end

   assign sts.kind        = req_ff.kind;
   assign sts.full        = total_ff >= TotW'(tkac_pkg::TableDepth);
   assign sts.empty       = total_ff == '0;
   assign sts.tail_cmp_gt = req_ff.access_count > cnt_a;
   assign sts.search_end  = pos_ff >= total_ff;
   assign sts.match       = blk_a == req_ff.block_number;
   assign sts.pos_zero    = pos_ff == '0;
   assign sts.pair_gt     = cnt_a > cnt_b;
   assign rsp_beat        = rsp_ff;

endmodule

FILE: rtl/tkac_ctrl.sv
// Controller state machine of the top-K table.
// Depends on tkac_pkg.
module tkac_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              strobe,
   input  tkac_pkg::sts_type sts,
   output tkac_pkg::cmd_type cmd
);

   tkac_pkg::state_type state_ff, state_in;
   logic tail_rd_ff, tail_rd_in;  // decide: tail read outstanding
   logic pending_new_ff, pending_new_in;

   always_comb begin
      state_in   = state_ff;
      tail_rd_in = tail_rd_ff;
      unique case (state_ff)
         tkac_pkg::ST_IDLE:
            if (start) begin
               state_in   = tkac_pkg::ST_DECIDE;
               tail_rd_in = 1'b0;
            end
         tkac_pkg::ST_DECIDE:
            priority case (sts.kind)
               tkac_pkg::KIND_OFFER:
                  if (!sts.full) begin
                     state_in = tkac_pkg::ST_BUB_READ;
                  end else if (!tail_rd_ff) begin
                     tail_rd_in = 1'b1;    // pos at tail, wait for the tail read
                  end else begin
                     state_in = tkac_pkg::ST_SEARCH_WAIT;
                  end
               tkac_pkg::KIND_UPDATE:  state_in = tkac_pkg::ST_SEARCH;
               tkac_pkg::KIND_DEQUEUE:
                  state_in = sts.empty ? tkac_pkg::ST_RESPOND : tkac_pkg::ST_DEQ_WAIT;
               default:                state_in = tkac_pkg::ST_RESPOND;
            endcase
         tkac_pkg::ST_SEARCH:
            // only update uses this state; offer goes straight to SEARCH_WAIT
            state_in = sts.search_end ? tkac_pkg::ST_BUB_READ : tkac_pkg::ST_SEARCH_WAIT;
         tkac_pkg::ST_SEARCH_WAIT:
            if (sts.kind == tkac_pkg::KIND_OFFER) begin
               state_in = sts.tail_cmp_gt ? tkac_pkg::ST_BUB_READ : tkac_pkg::ST_RESPOND;
            end else begin
               state_in = sts.match ? tkac_pkg::ST_BUB_READ : tkac_pkg::ST_SEARCH;
            end
         tkac_pkg::ST_BUB_READ:
            state_in = sts.pos_zero ? tkac_pkg::ST_RESPOND : tkac_pkg::ST_BUB_WAIT;
         tkac_pkg::ST_BUB_WAIT: state_in = tkac_pkg::ST_BUB_CMP;
         tkac_pkg::ST_BUB_CMP:
            state_in = sts.pair_gt ? tkac_pkg::ST_BUB_READ : tkac_pkg::ST_RESPOND;
         tkac_pkg::ST_DEQ_WAIT: state_in = tkac_pkg::ST_RESPOND;
         tkac_pkg::ST_RESPOND:  state_in = tkac_pkg::ST_IDLE;
         default:               state_in = tkac_pkg::ST_IDLE;
      endcase
   end

   // Outputs. Writes land in BUB_READ entry so the following read sees them.
   always_comb begin
      cmd    = '0;
      busy   = state_ff != tkac_pkg::ST_IDLE;
      strobe = state_ff == tkac_pkg::ST_RESPOND;
      unique case (state_ff)
         tkac_pkg::ST_IDLE: cmd.latch_req = start;
         tkac_pkg::ST_DECIDE:
            priority case (sts.kind)
               tkac_pkg::KIND_OFFER: begin
                  // non-full: insert at tail now; full: point at tail and read
                  cmd.load_tail = !tail_rd_ff;
                  cmd.insert    = !sts.full;
                  cmd.read_pos  = 1'b1;
               end
               tkac_pkg::KIND_UPDATE:  cmd.pos_clear = 1'b1;
               tkac_pkg::KIND_DEQUEUE: begin
                  cmd.set_status_empty = sts.empty;
                  cmd.read_head        = 1'b1;
               end
               default: ;
            endcase
         tkac_pkg::ST_SEARCH: begin
            cmd.read_pos = 1'b1;
            if (sts.search_end) begin
               cmd.load_tail = 1'b1;
               cmd.insert    = !sts.full;
            end
         end
         tkac_pkg::ST_SEARCH_WAIT:
            if (sts.kind == tkac_pkg::KIND_OFFER) begin
               cmd.set_status_rej = !sts.tail_cmp_gt;
            end else if (sts.match) begin
               cmd.write_hit = 1'b1;
               cmd.set_hit   = 1'b1;
            end else begin
               cmd.pos_inc = 1'b1;
            end
         tkac_pkg::ST_BUB_READ: cmd.read_pair = 1'b1;
         tkac_pkg::ST_BUB_WAIT: cmd.read_pair = 1'b1;
         tkac_pkg::ST_BUB_CMP:  cmd.swap = sts.pair_gt;
         tkac_pkg::ST_DEQ_WAIT: cmd.dequeue = 1'b1;
         tkac_pkg::ST_RESPOND:  cmd.respond = 1'b1;
         default: ;
      endcase
      // the new entry is written on the first bubble read after a load
      if (state_ff == tkac_pkg::ST_BUB_READ && pending_new_ff) begin
         cmd.write_new = 1'b1;
      end
   end

   always_comb begin
      pending_new_in = pending_new_ff;
      if (cmd.load_tail && state_ff == tkac_pkg::ST_SEARCH) pending_new_in = 1'b1;
      if (state_ff == tkac_pkg::ST_DECIDE && sts.kind == tkac_pkg::KIND_OFFER
          && !sts.full) pending_new_in = 1'b1;
      if (state_ff == tkac_pkg::ST_SEARCH_WAIT && sts.kind == tkac_pkg::KIND_OFFER
          && sts.tail_cmp_gt) pending_new_in = 1'b1;
      if (state_ff == tkac_pkg::ST_BUB_READ) pending_new_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tkac_pkg::ST_IDLE;
         tail_rd_ff     <= 1'b0;
         pending_new_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tail_rd_ff     <= tail_rd_in;
         pending_new_ff <= pending_new_in;
      end
   end

endmodule

FILE: rtl/tkac_checker.sv
// Port-level checker for the top-K table, bound to the top level.
// Depends on tkac_pkg.
module tkac_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input tkac_pkg::rsp_type rsp_beat
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised on accept");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("response outside busy");

   a_strobe_release: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe) else $error("busy held after response");

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_beat.occupancy <= tkac_pkg::OccW'(tkac_pkg::TableDepth))
      else $error("occupancy out of range");

endmodule

bind top_k_access_count_table_top tkac_checker u_checker (
   .clock, .reset, .start, .busy, .rsp_strobe, .rsp_beat
);
